// ===== rtl/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and constants shared by the snapshot stream parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Parse phases
    localparam logic [3:0] PH_MAGIC    = 4'd0;
    localparam logic [3:0] PH_VERSION  = 4'd1;
    localparam logic [3:0] PH_OPCODE   = 4'd2;
    localparam logic [3:0] PH_DBSKIP   = 4'd3;
    localparam logic [3:0] PH_EXPIRE   = 4'd4;
    localparam logic [3:0] PH_TYPE     = 4'd5;
    localparam logic [3:0] PH_LENFIRST = 4'd6;
    localparam logic [3:0] PH_LEN14    = 4'd7;
    localparam logic [3:0] PH_LEN32    = 4'd8;
    localparam logic [3:0] PH_STRING   = 4'd9;
    localparam logic [3:0] PH_CRC      = 4'd10;
    localparam logic [3:0] PH_DONE     = 4'd11;

    // Input functions
    localparam logic [1:0] FUNC_DATA  = 2'd0;
    localparam logic [1:0] FUNC_EOF   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_KEY   = 3'd0;
    localparam logic [2:0] KIND_VALUE = 3'd1;
    localparam logic [2:0] KIND_ENTRY = 3'd2;
    localparam logic [2:0] KIND_OK    = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_EARLY    = 3'd1;
    localparam logic [2:0] ERR_MAGIC    = 3'd2;
    localparam logic [2:0] ERR_VERSION  = 3'd3;
    localparam logic [2:0] ERR_LENGTH   = 3'd4;
    localparam logic [2:0] ERR_CRC_MISS = 3'd5;
    localparam logic [2:0] ERR_CRC_BAD  = 3'd6;

    // Register addresses (word index)
    localparam logic [2:0] REG_MAX_VERSION = 3'd0;
    localparam logic [2:0] REG_CODE_END    = 3'd1;
    localparam logic [2:0] REG_CODE_SELDB  = 3'd2;
    localparam logic [2:0] REG_CODE_EXPIRE = 3'd3;
    localparam logic [2:0] REG_CODE_STRING = 3'd4;

    // Length prefix forms
    localparam logic [1:0] LEN_6BIT  = 2'b00;
    localparam logic [1:0] LEN_BAD   = 2'b01;
    localparam logic [1:0] LEN_14BIT = 2'b10;
    localparam logic [1:0] LEN_32BIT = 2'b11;

    localparam logic [63:0] CRC_POLY   = 64'had93d23594c935a9;
    localparam logic [63:0] MAGIC_WORD = 64'h0000_0000_4156_454b;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic        string_last;
        logic        has_expire;
        logic [63:0] expire_time;
        logic [2:0]  error_code;
        logic [31:0] entry_count;
        logic        run_last;
    } result_t;

    // Reflected CRC-64 update, one byte
    function automatic logic [63:0] crc_update(input logic [63:0] crc, input logic [7:0] b);
        logic [63:0] c;
        c = ~crc ^ {56'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

// ===== rtl/snapshot_stream_parser_crc64.sv =====
// ----------------------------------------------------------------------------
// snapshot_stream_parser_crc64
// Byte-serial snapshot parser: magic/version check, opcode records, key and
// value strings, and a trailing reflected CRC-64 check.
// ----------------------------------------------------------------------------
// Results of an accepted beat, at most two, are registered into the 4-entry
//   output queue, which drains one result per cycle while out_ready is high.
// Throughput: one input beat per cycle while in_ready is high.
// in_ready is high while the queue has room for two results.
// Reset: asynchronous, active low; registers take their defaults and a new
//   load starts, with the output queue empty.
module snapshot_stream_parser_crc64
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic        string_last,
    output logic        has_expire,
    output logic signed [63:0] expire_time,
    output logic [2:0]  error_code,
    output logic [31:0] entry_count,
    output logic        run_last
);

    // Configuration registers
    logic [15:0] max_version_reg;
    logic [7:0]  code_end_reg, code_seldb_reg, code_expire_reg, code_string_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_version_reg <= 16'd1;
            code_end_reg    <= 8'd255;
            code_seldb_reg  <= 8'd254;
            code_expire_reg <= 8'd252;
            code_string_reg <= 8'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                ssp_pkg::REG_MAX_VERSION: max_version_reg <= pwdata[15:0];
                ssp_pkg::REG_CODE_END:    code_end_reg    <= pwdata[7:0];
                ssp_pkg::REG_CODE_SELDB:  code_seldb_reg  <= pwdata[7:0];
                ssp_pkg::REG_CODE_EXPIRE: code_expire_reg <= pwdata[7:0];
                ssp_pkg::REG_CODE_STRING: code_string_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            ssp_pkg::REG_MAX_VERSION: prdata = {16'd0, max_version_reg};
            ssp_pkg::REG_CODE_END:    prdata = {24'd0, code_end_reg};
            ssp_pkg::REG_CODE_SELDB:  prdata = {24'd0, code_seldb_reg};
            ssp_pkg::REG_CODE_EXPIRE: prdata = {24'd0, code_expire_reg};
            ssp_pkg::REG_CODE_STRING: prdata = {24'd0, code_string_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // Parser state
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  fbc_reg, fbc_next;
    logic [63:0] fval_reg, fval_next;
    logic [31:0] srem_reg, srem_next;
    logic        rdval_reg, rdval_next;
    logic [63:0] pexp_reg, pexp_next;
    logic [63:0] crc_reg, crc_next;
    logic [31:0] cnt_reg, cnt_next;

    ssp_pkg::result_t res0, res1;
    logic        res0_vld, res1_vld;
    logic        in_fire;

    assign in_fire = in_valid && in_ready;

    // Next-state and result logic for one beat
    always_comb
    begin
        logic [63:0] gval;
        logic [3:0]  gcnt;
        logic [31:0] blen;
        logic        bstart;
        logic        edone;
        logic [31:0] srem_dec;

        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        fval_next  = fval_reg;
        srem_next  = srem_reg;
        rdval_next = rdval_reg;
        pexp_next  = pexp_reg;
        crc_next   = crc_reg;
        cnt_next   = cnt_reg;
        res0       = '0;
        res1       = '0;
        res0_vld   = 1'b0;
        res1_vld   = 1'b0;
        bstart     = 1'b0;
        blen       = 32'd0;
        edone      = 1'b0;
        srem_dec   = srem_reg - 32'd1;

        gval = fval_reg | ({56'd0, data_byte} << {fbc_reg[2:0], 3'b000});
        gcnt = fbc_reg + 4'd1;

        res0.entry_count = cnt_reg;

        if (func == ssp_pkg::FUNC_START)
        begin
            phase_next = ssp_pkg::PH_MAGIC;
            fbc_next   = 4'd0;
            fval_next  = 64'd0;
            srem_next  = 32'd0;
            rdval_next = 1'b0;
            pexp_next  = '1;
            crc_next   = 64'd0;
            cnt_next   = 32'd0;
        end
        else if (func == ssp_pkg::FUNC_EOF)
        begin
            if (phase_reg != ssp_pkg::PH_DONE)
            begin
                res0_vld        = 1'b1;
                res0.kind       = ssp_pkg::KIND_ERROR;
                res0.error_code = (phase_reg == ssp_pkg::PH_CRC) ?
                                  ssp_pkg::ERR_CRC_MISS : ssp_pkg::ERR_EARLY;
                phase_next      = ssp_pkg::PH_DONE;
            end
        end
        else if (func == ssp_pkg::FUNC_DATA)
        begin
            if (phase_reg != ssp_pkg::PH_CRC && phase_reg != ssp_pkg::PH_DONE)
                crc_next = ssp_pkg::crc_update(crc_reg, data_byte);

            unique case (phase_reg)
                ssp_pkg::PH_MAGIC:
                begin
                    fval_next = gval;
                    fbc_next  = gcnt;
                    if (gcnt >= 4'd4)
                    begin
                        if (gval != ssp_pkg::MAGIC_WORD)
                        begin
                            res0_vld        = 1'b1;
                            res0.kind       = ssp_pkg::KIND_ERROR;
                            res0.error_code = ssp_pkg::ERR_MAGIC;
                            phase_next      = ssp_pkg::PH_DONE;
                        end
                        else
                        begin
                            phase_next = ssp_pkg::PH_VERSION;
                            fbc_next   = 4'd0;
                            fval_next  = 64'd0;
                        end
                    end
                end
                ssp_pkg::PH_VERSION:
                begin
                    fval_next = gval;
                    fbc_next  = gcnt;
                    if (gcnt >= 4'd2)
                    begin
                        if (gval > {48'd0, max_version_reg})
                        begin
                            res0_vld        = 1'b1;
                            res0.kind       = ssp_pkg::KIND_ERROR;
                            res0.error_code = ssp_pkg::ERR_VERSION;
                            phase_next      = ssp_pkg::PH_DONE;
                        end
                        else
                            phase_next = ssp_pkg::PH_OPCODE;
                    end
                end
                ssp_pkg::PH_OPCODE:
                begin
                    if (data_byte == code_end_reg)
                    begin
                        phase_next = ssp_pkg::PH_CRC;
                        fbc_next   = 4'd0;
                        fval_next  = 64'd0;
                    end
                    else if (data_byte == code_seldb_reg)
                    begin
                        phase_next = ssp_pkg::PH_DBSKIP;
                        fbc_next   = 4'd0;
                        fval_next  = 64'd0;
                    end
                    else if (data_byte == code_expire_reg)
                    begin
                        phase_next = ssp_pkg::PH_EXPIRE;
                        fbc_next   = 4'd0;
                        fval_next  = 64'd0;
                    end
                    else if (data_byte == code_string_reg)
                    begin
                        rdval_next = 1'b0;
                        phase_next = ssp_pkg::PH_LENFIRST;
                    end
                end
                ssp_pkg::PH_DBSKIP:
                begin
                    fbc_next = gcnt;
                    if (gcnt >= 4'd4)
                        phase_next = ssp_pkg::PH_OPCODE;
                end
                ssp_pkg::PH_EXPIRE:
                begin
                    fval_next = gval;
                    fbc_next  = gcnt;
                    if (gcnt >= 4'd8)
                    begin
                        pexp_next  = gval;
                        phase_next = ssp_pkg::PH_TYPE;
                    end
                end
                ssp_pkg::PH_TYPE:
                begin
                    if (data_byte == code_string_reg)
                    begin
                        rdval_next = 1'b0;
                        phase_next = ssp_pkg::PH_LENFIRST;
                    end
                    else
                        phase_next = ssp_pkg::PH_OPCODE;
                end
                ssp_pkg::PH_LENFIRST:
                begin
                    case (data_byte[7:6])
                        ssp_pkg::LEN_6BIT:
                        begin
                            bstart = 1'b1;
                            blen   = {26'd0, data_byte[5:0]};
                        end
                        ssp_pkg::LEN_14BIT:
                        begin
                            phase_next = ssp_pkg::PH_LEN14;
                            fbc_next   = 4'd0;
                            fval_next  = {58'd0, data_byte[5:0]};
                        end
                        ssp_pkg::LEN_32BIT:
                        begin
                            phase_next = ssp_pkg::PH_LEN32;
                            fbc_next   = 4'd0;
                            fval_next  = 64'd0;
                        end
                        default:
                        begin
                            res0_vld        = 1'b1;
                            res0.kind       = ssp_pkg::KIND_ERROR;
                            res0.error_code = ssp_pkg::ERR_LENGTH;
                            phase_next      = ssp_pkg::PH_DONE;
                        end
                    endcase
                end
                ssp_pkg::PH_LEN14:
                begin
                    bstart = 1'b1;
                    blen   = {18'd0, fval_reg[5:0], data_byte};
                end
                ssp_pkg::PH_LEN32:
                begin
                    fval_next = gval;
                    fbc_next  = gcnt;
                    if (gcnt >= 4'd4)
                    begin
                        bstart = 1'b1;
                        blen   = gval[31:0];
                    end
                end
                ssp_pkg::PH_STRING:
                begin
                    res0_vld         = 1'b1;
                    res0.kind        = rdval_reg ? ssp_pkg::KIND_VALUE : ssp_pkg::KIND_KEY;
                    res0.out_byte    = data_byte;
                    res0.string_last = (srem_reg == 32'd1);
                    if (srem_reg != 32'd0)
                        srem_next = srem_dec;
                    if (srem_reg <= 32'd1)
                    begin
                        if (!rdval_reg)
                        begin
                            rdval_next = 1'b1;
                            phase_next = ssp_pkg::PH_LENFIRST;
                        end
                        else
                            edone = 1'b1;
                    end
                end
                ssp_pkg::PH_CRC:
                begin
                    fval_next = gval;
                    fbc_next  = gcnt;
                    if (gcnt >= 4'd8)
                    begin
                        res0_vld   = 1'b1;
                        phase_next = ssp_pkg::PH_DONE;
                        if (gval != crc_reg)
                        begin
                            res0.kind       = ssp_pkg::KIND_ERROR;
                            res0.error_code = ssp_pkg::ERR_CRC_BAD;
                        end
                        else
                            res0.kind = ssp_pkg::KIND_OK;
                    end
                end
                default: ;
            endcase

            // String start after a length field
            if (bstart)
            begin
                srem_next = blen;
                if (blen != 32'd0)
                    phase_next = ssp_pkg::PH_STRING;
                else if (!rdval_reg)
                begin
                    rdval_next = 1'b1;
                    phase_next = ssp_pkg::PH_LENFIRST;
                end
                else
                    edone = 1'b1;
            end

            // Entry complete
            if (edone)
            begin
                ssp_pkg::result_t er;
                er             = '0;
                er.kind        = ssp_pkg::KIND_ENTRY;
                er.has_expire  = (pexp_reg != '1);
                er.expire_time = er.has_expire ? pexp_reg : 64'd0;
                cnt_next       = (cnt_reg != '1) ? cnt_reg + 32'd1 : cnt_reg;
                er.entry_count = cnt_next;
                pexp_next      = '1;
                rdval_next     = 1'b0;
                phase_next     = ssp_pkg::PH_OPCODE;
                if (res0_vld)
                begin
                    res1     = er;
                    res1_vld = 1'b1;
                end
                else
                begin
                    res0     = er;
                    res0_vld = 1'b1;
                end
            end
        end

        res0.run_last = !res1_vld;
        res1.run_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ssp_pkg::PH_MAGIC;
            fbc_reg   <= 4'd0;
            fval_reg  <= 64'd0;
            srem_reg  <= 32'd0;
            rdval_reg <= 1'b0;
            pexp_reg  <= '1;
            crc_reg   <= 64'd0;
            cnt_reg   <= 32'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            fval_reg  <= fval_next;
            srem_reg  <= srem_next;
            rdval_reg <= rdval_next;
            pexp_reg  <= pexp_next;
            crc_reg   <= crc_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Output queue, 4 entries
    ssp_pkg::result_t q_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] qcnt_reg;
    logic       pop;
    logic [1:0] push_n;

    assign in_ready  = (qcnt_reg <= 3'd2);
    assign out_valid = (qcnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;
    assign push_n    = in_fire ? ({1'b0, res0_vld} + {1'b0, res1_vld}) : 2'd0;

    always_ff @(posedge clk)
    begin
        if (in_fire && res0_vld)
            q_reg[wptr_reg] <= res0;
        if (in_fire && res1_vld)
            q_reg[wptr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 2'd0;
            rptr_reg <= 2'd0;
            qcnt_reg <= 3'd0;
        end
        else
        begin
            wptr_reg <= wptr_reg + push_n;
            if (pop)
                rptr_reg <= rptr_reg + 2'd1;
            qcnt_reg <= qcnt_reg + {1'b0, push_n} - {2'd0, pop};
        end
    end

    assign kind        = q_reg[rptr_reg].kind;
    assign out_byte    = q_reg[rptr_reg].out_byte;
    assign string_last = q_reg[rptr_reg].string_last;
    assign has_expire  = q_reg[rptr_reg].has_expire;
    assign expire_time = q_reg[rptr_reg].expire_time;
    assign error_code  = q_reg[rptr_reg].error_code;
    assign entry_count = q_reg[rptr_reg].entry_count;
    assign run_last    = q_reg[rptr_reg].run_last;

endmodule

// ===== tb/sv/snapshot_stream_parser_crc64_tb.sv =====
// ----------------------------------------------------------------------------
// snapshot_stream_parser_crc64_tb
// Self-checking bench for the snapshot parser. Builds snapshot files (magic,
// version, records, end code, CRC-64) under several register settings, some
// clean and some corrupted or cut short, streams them with random gaps and
// output stalls, and checks every result beat against a built-in predictor.
// ----------------------------------------------------------------------------
module snapshot_stream_parser_crc64_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // func code with no meaning, must be ignored
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Parser predictor and expected-result store
    // ------------------------------------------------------------------------
    class snapshot_checker;
        logic [15:0] max_ver;
        logic [7:0]  c_end, c_sel, c_exp, c_str;
        logic [3:0]  ph;
        logic [3:0]  fcnt;
        logic [63:0] fval;
        logic [31:0] remaining;
        bit          rdval;
        logic [63:0] pexp;
        logic [63:0] crc;
        logic [31:0] nloaded;
        ssp_pkg::result_t pending_results[$];
        int          mismatches;

        function new();
            max_ver = 16'd1;
            c_end = 8'd255;
            c_sel = 8'd254;
            c_exp = 8'd252;
            c_str = 8'd0;
            mismatches = 0;
            restart();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                ssp_pkg::REG_MAX_VERSION: max_ver = v[15:0];
                ssp_pkg::REG_CODE_END:    c_end = v[7:0];
                ssp_pkg::REG_CODE_SELDB:  c_sel = v[7:0];
                ssp_pkg::REG_CODE_EXPIRE: c_exp = v[7:0];
                ssp_pkg::REG_CODE_STRING: c_str = v[7:0];
                default: ;
            endcase
        endfunction

        function void restart();
            ph = ssp_pkg::PH_MAGIC;
            fcnt = 4'd0;
            fval = 64'd0;
            remaining = 32'd0;
            rdval = 1'b0;
            pexp = '1;
            crc = 64'd0;
            nloaded = 32'd0;
        endfunction

        // reflected CRC-64, complemented around each byte
        function logic [63:0] crc_step(logic [63:0] cur, logic [7:0] b);
            logic [63:0] c;
            c = ~cur ^ {56'd0, b};
            for (int i = 0; i < 8; i++)
                c = c[0] ? (ssp_pkg::CRC_POLY ^ (c >> 1)) : (c >> 1);
            return ~c;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] b, bit last, bit hexp,
                           logic [63:0] et, logic [2:0] err);
            ssp_pkg::result_t r;
            r.kind = k;
            r.out_byte = b;
            r.string_last = last;
            r.has_expire = hexp;
            r.expire_time = et;
            r.error_code = err;
            r.entry_count = nloaded;
            r.run_last = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void fail(logic [2:0] err);
            emit(ssp_pkg::KIND_ERROR, 8'd0, 1'b0, 1'b0, 64'd0, err);
            ph = ssp_pkg::PH_DONE;
        endfunction

        function void gather(logic [7:0] b);
            fval |= {56'd0, b} << {fcnt[2:0], 3'b000};
            fcnt = fcnt + 4'd1;
        endfunction

        function void begin_field(logic [3:0] p);
            ph = p;
            fcnt = 4'd0;
            fval = 64'd0;
        endfunction

        function void entry_done();
            bit hexp;
            hexp = (pexp != '1);
            if (nloaded != '1)
                nloaded++;
            emit(ssp_pkg::KIND_ENTRY, 8'd0, 1'b0, hexp, hexp ? pexp : 64'd0,
                 ssp_pkg::ERR_NONE);
            pexp = '1;
            rdval = 1'b0;
            ph = ssp_pkg::PH_OPCODE;
        endfunction

        function void begin_string(logic [31:0] len);
            remaining = len;
            if (len != 32'd0)
                ph = ssp_pkg::PH_STRING;
            else if (!rdval)
            begin
                rdval = 1'b1;
                ph = ssp_pkg::PH_LENFIRST;
            end
            else
                entry_done();
        endfunction

        function void parse_byte(logic [7:0] b);
            if (ph != ssp_pkg::PH_CRC && ph != ssp_pkg::PH_DONE)
                crc = crc_step(crc, b);
            case (ph)
                ssp_pkg::PH_MAGIC:
                begin
                    gather(b);
                    if (fcnt >= 4'd4)
                    begin
                        if (fval != ssp_pkg::MAGIC_WORD) fail(ssp_pkg::ERR_MAGIC);
                        else begin_field(ssp_pkg::PH_VERSION);
                    end
                end
                ssp_pkg::PH_VERSION:
                begin
                    gather(b);
                    if (fcnt >= 4'd2)
                    begin
                        if (fval > {48'd0, max_ver}) fail(ssp_pkg::ERR_VERSION);
                        else ph = ssp_pkg::PH_OPCODE;
                    end
                end
                ssp_pkg::PH_OPCODE:
                begin
                    if (b == c_end) begin_field(ssp_pkg::PH_CRC);
                    else if (b == c_sel) begin_field(ssp_pkg::PH_DBSKIP);
                    else if (b == c_exp) begin_field(ssp_pkg::PH_EXPIRE);
                    else if (b == c_str)
                    begin
                        rdval = 1'b0;
                        ph = ssp_pkg::PH_LENFIRST;
                    end
                end
                ssp_pkg::PH_DBSKIP:
                begin
                    fcnt = fcnt + 4'd1;
                    if (fcnt >= 4'd4) ph = ssp_pkg::PH_OPCODE;
                end
                ssp_pkg::PH_EXPIRE:
                begin
                    gather(b);
                    if (fcnt >= 4'd8)
                    begin
                        pexp = fval;
                        ph = ssp_pkg::PH_TYPE;
                    end
                end
                ssp_pkg::PH_TYPE:
                begin
                    if (b == c_str)
                    begin
                        rdval = 1'b0;
                        ph = ssp_pkg::PH_LENFIRST;
                    end
                    else
                        ph = ssp_pkg::PH_OPCODE;
                end
                ssp_pkg::PH_LENFIRST:
                begin
                    case (b[7:6])
                        ssp_pkg::LEN_6BIT:  begin_string({26'd0, b[5:0]});
                        ssp_pkg::LEN_14BIT:
                        begin
                            begin_field(ssp_pkg::PH_LEN14);
                            fval = {58'd0, b[5:0]};
                        end
                        ssp_pkg::LEN_32BIT: begin_field(ssp_pkg::PH_LEN32);
                        default:            fail(ssp_pkg::ERR_LENGTH);
                    endcase
                end
                ssp_pkg::PH_LEN14: begin_string({18'd0, fval[5:0], b});
                ssp_pkg::PH_LEN32:
                begin
                    gather(b);
                    if (fcnt >= 4'd4) begin_string(fval[31:0]);
                end
                ssp_pkg::PH_STRING:
                begin
                    emit(rdval ? ssp_pkg::KIND_VALUE : ssp_pkg::KIND_KEY, b,
                         remaining == 32'd1, 1'b0, 64'd0, ssp_pkg::ERR_NONE);
                    if (remaining != 32'd0) remaining--;
                    if (remaining == 32'd0)
                    begin
                        if (!rdval)
                        begin
                            rdval = 1'b1;
                            ph = ssp_pkg::PH_LENFIRST;
                        end
                        else
                            entry_done();
                    end
                end
                ssp_pkg::PH_CRC:
                begin
                    gather(b);
                    if (fcnt >= 4'd8)
                    begin
                        if (fval != crc) fail(ssp_pkg::ERR_CRC_BAD);
                        else
                        begin
                            emit(ssp_pkg::KIND_OK, 8'd0, 1'b0, 1'b0, 64'd0,
                                 ssp_pkg::ERR_NONE);
                            ph = ssp_pkg::PH_DONE;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // accepted input beat
        function void note_beat(logic [1:0] f, logic [7:0] b);
            int n0;
            n0 = pending_results.size();
            if (f == ssp_pkg::FUNC_START)
                restart();
            else if (f == ssp_pkg::FUNC_DATA)
                parse_byte(b);
            else if (f == ssp_pkg::FUNC_EOF)
            begin
                if (ph == ssp_pkg::PH_CRC) fail(ssp_pkg::ERR_CRC_MISS);
                else if (ph != ssp_pkg::PH_DONE) fail(ssp_pkg::ERR_EARLY);
            end
            if (pending_results.size() > n0)
                pending_results[pending_results.size() - 1].run_last = 1'b1;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // accepted result beat
        task check_result(ssp_pkg::result_t got);
            ssp_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.string_last !== want.string_last)
                report($sformatf("string_last %b, want %b", got.string_last,
                                 want.string_last));
            if (got.has_expire !== want.has_expire)
                report($sformatf("has_expire %b, want %b", got.has_expire,
                                 want.has_expire));
            if (got.expire_time !== want.expire_time)
                report($sformatf("expire_time %h, want %h", got.expire_time,
                                 want.expire_time));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, want %0d", got.error_code,
                                 want.error_code));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, want %0d", got.entry_count,
                                 want.entry_count));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               in_valid, in_ready;
    logic [1:0]         func;
    logic [7:0]         data_byte;
    logic               out_valid, out_ready;
    logic [2:0]         kind;
    logic [7:0]         out_byte;
    logic               string_last, has_expire;
    logic signed [63:0] expire_time;
    logic [2:0]         error_code;
    logic [31:0]        entry_count;
    logic               run_last;

    snapshot_stream_parser_crc64 DUT (.*);

    snapshot_checker sb = new();
    int beats_sent;
    int burst_left;
    int cyc;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("** snapshot_stream_parser_crc64: FAILED **");
        $finish;
    end

    // receiver stall pattern: open, random, mostly closed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyc <= 0;
            out_ready <= 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            case ((cyc / 317) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // beat monitor
    always @(posedge clk)
    begin
        ssp_pkg::result_t r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_beat(func, data_byte);
            if (out_valid && out_ready)
            begin
                r = '{kind, out_byte, string_last, has_expire, expire_time,
                      error_code, entry_count, run_last};
                sb.check_result(r);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task send_beat(logic [1:0] f, logic [7:0] b);
        in_valid <= 1'b1;
        func <= f;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task set_codes(logic [15:0] mv, logic [7:0] e, logic [7:0] s, logic [7:0] x,
                   logic [7:0] st);
        reg_write(ssp_pkg::REG_MAX_VERSION, {16'd0, mv});
        reg_write(ssp_pkg::REG_CODE_END, {24'd0, e});
        reg_write(ssp_pkg::REG_CODE_SELDB, {24'd0, s});
        reg_write(ssp_pkg::REG_CODE_EXPIRE, {24'd0, x});
        reg_write(ssp_pkg::REG_CODE_STRING, {24'd0, st});
    endtask

    // ------------------------------------------------------------------------
    // Snapshot file builder
    // ------------------------------------------------------------------------
    task automatic add_string(ref logic [7:0] q[$]);
        int len;
        int form;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 70) : $urandom_range(0, 6);
        form = $urandom_range(0, 3);
        if (form <= 1 && len < 64)
            q.push_back({ssp_pkg::LEN_6BIT, 6'(len)});
        else if (form == 2 || len >= 64)
        begin
            q.push_back({ssp_pkg::LEN_14BIT, 6'(len >> 8)});
            q.push_back(8'(len));
        end
        else
        begin
            q.push_back({ssp_pkg::LEN_32BIT, 6'($urandom)});
            for (int i = 0; i < 4; i++) q.push_back(8'(len >> (8 * i)));
        end
        for (int i = 0; i < len; i++) q.push_back(8'($urandom));
    endtask

    task automatic add_entry(ref logic [7:0] q[$]);
        if ($urandom_range(0, 29) == 0)
            q.push_back({ssp_pkg::LEN_BAD, 6'($urandom)});
        else
        begin
            add_string(q);
            add_string(q);
        end
    endtask

    task automatic build_file(ref logic [7:0] q[$], output bit cut);
        logic [15:0] ver;
        logic [63:0] c;
        logic [7:0]  b;
        int n;
        int mode;
        q = {};
        cut = 0;
        for (int i = 0; i < 4; i++) q.push_back(ssp_pkg::MAGIC_WORD[8*i +: 8]);
        ver = 16'($urandom_range(sb.max_ver, 0));
        if (sb.max_ver != 16'hFFFF && $urandom_range(0, 14) == 0)
            ver = sb.max_ver + 16'd1;
        q.push_back(ver[7:0]);
        q.push_back(ver[15:8]);
        n = $urandom_range(1, 6);
        for (int r = 0; r < n; r++)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    q.push_back(sb.c_sel);
                    repeat (4) q.push_back(8'($urandom));
                end
                1, 2:
                begin
                    q.push_back(sb.c_exp);
                    b = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'h00;
                    repeat (8) q.push_back(b == 8'hFF ? b : 8'($urandom));
                    if ($urandom_range(0, 3) != 0)
                    begin
                        q.push_back(sb.c_str);
                        add_entry(q);
                    end
                    else
                        q.push_back(8'($urandom));
                end
                3:
                begin
                    b = 8'($urandom);
                    if (b == sb.c_end || b == sb.c_sel || b == sb.c_exp || b == sb.c_str)
                        b = b ^ 8'h5A;
                    q.push_back(b);
                end
                default:
                begin
                    q.push_back(sb.c_str);
                    add_entry(q);
                end
            endcase
        end
        q.push_back(sb.c_end);
        c = 64'd0;
        foreach (q[i]) c = sb.crc_step(c, q[i]);
        for (int i = 0; i < 8; i++) q.push_back(c[8*i +: 8]);
        // corruption
        mode = $urandom_range(0, 11);
        if (mode == 8)
            q[$urandom_range(0, q.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        else if (mode == 9)
        begin
            q = q[0 : $urandom_range(0, q.size() - 1)];
            cut = 1;
        end
        else if (mode == 10)
            q[q.size() - 1 - $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    endtask

    task run_file();
        logic [7:0] q[$];
        bit cut;
        build_file(q, cut);
        if ($urandom_range(0, 19) == 0) wait_drain();
        send_beat(ssp_pkg::FUNC_START, 8'($urandom));
        foreach (q[i])
        begin
            if ($urandom_range(0, 59) == 0) send_beat(FUNC_UNUSED, 8'($urandom));
            send_beat(ssp_pkg::FUNC_DATA, q[i]);
        end
        if (cut) send_beat(ssp_pkg::FUNC_EOF, 8'($urandom));
        case ($urandom_range(0, 3))
            0: send_beat(ssp_pkg::FUNC_EOF, 8'($urandom));
            1: repeat ($urandom_range(1, 3)) send_beat(ssp_pkg::FUNC_DATA, 8'($urandom));
            default: ;
        endcase
    endtask

    task run_phase(int beats);
        int stop_at;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) run_file();
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0]  q[$];
        logic [63:0] c;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        func = ssp_pkg::FUNC_DATA;
        data_byte = 8'd0;
        beats_sent = 0;
        burst_left = 8;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: minimal file with an empty key and value at reset settings
        q = {};
        for (int i = 0; i < 4; i++) q.push_back(ssp_pkg::MAGIC_WORD[8*i +: 8]);
        q = {q, 8'h01, 8'h00, sb.c_str, 8'h00, 8'h00, sb.c_end};
        c = 64'd0;
        foreach (q[i]) c = sb.crc_step(c, q[i]);
        for (int i = 0; i < 8; i++) q.push_back(c[8*i +: 8]);
        send_beat(ssp_pkg::FUNC_START, 8'hFF);
        foreach (q[i]) send_beat(ssp_pkg::FUNC_DATA, q[i]);
        send_beat(ssp_pkg::FUNC_EOF, 8'h00);
        // bad magic, then an unused func, then early end
        send_beat(ssp_pkg::FUNC_START, 8'h00);
        for (int i = 0; i < 4; i++)
            send_beat(ssp_pkg::FUNC_DATA, ~ssp_pkg::MAGIC_WORD[8*i +: 8]);
        send_beat(ssp_pkg::FUNC_START, 8'h00);
        send_beat(FUNC_UNUSED, 8'hFF);
        send_beat(ssp_pkg::FUNC_EOF, 8'hFF);
        wait_drain();

        // random files across register settings
        run_phase(280);
        set_codes(16'hFFFF, 8'd0, 8'd1, 8'd2, 8'd255);
        run_phase(280);
        set_codes(16'h0000, 8'd255, 8'd254, 8'd253, 8'd128);
        run_phase(280);
        repeat (3)
        begin
            set_codes(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
            run_phase(280);
        end

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("** snapshot_stream_parser_crc64: PASSED **");
        else
            $display("** snapshot_stream_parser_crc64: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ssp_pkg.sv
rtl/snapshot_stream_parser_crc64.sv
tb/sv/snapshot_stream_parser_crc64_tb.sv
